>>> rtl/core/trd_pkg.sv
// -----------------------------------------------------------------------------
// Tilemap RLE decoder package
// Shared constants and the command record passed from front end to back end.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trd_pkg;

  // Largest map the attribute store can hold.
  localparam int unsigned MaxTiles = 4096;
  localparam int unsigned AddrW    = $clog2(MaxTiles);
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);

  // Decoder phases.
  localparam logic [2:0] PH_HDR_W  = 3'd0;
  localparam logic [2:0] PH_HDR_H  = 3'd1;
  localparam logic [2:0] PH_ATTR_A = 3'd2;
  localparam logic [2:0] PH_ATTR_B = 3'd3;
  localparam logic [2:0] PH_IDX_A  = 3'd4;
  localparam logic [2:0] PH_IDX_B  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_ERROR  = 3'd7;

  // Status codes.
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_ATTR_OVF  = 3'd3;
  localparam logic [2:0] ST_ATTR_MISM = 3'd4;
  localparam logic [2:0] ST_IDX_OVF   = 3'd5;
  localparam logic [2:0] ST_NO_LAST   = 3'd6;
  localparam logic [2:0] ST_NO_INCR   = 3'd7;

  localparam logic [10:0] IdxEnd = 11'h7FF;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ATTR = 2'd1,
    CMD_EMIT = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [AddrW-1:0] addr;
    logic [9:0]       count;   // tiles minus one
    logic [4:0]       attr;
    logic [10:0]      index;
    logic             step;    // index rises by one per tile
    logic [2:0]       status;
    logic [7:0]       width;
    logic [7:0]       height;
  } cmd_t;

endpackage

>>> rtl/core/trd_if.sv
// -----------------------------------------------------------------------------
// Tilemap RLE decoder channels
// Byte input channel and tile result channel, valid/ready handshake.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface trd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_start;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_start,
                  output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_start,
                  input stream_end, output ready);
endinterface

interface trd_tile_if;
  logic        valid;
  logic        ready;
  logic [15:0] tile_value;
  logic [11:0] tile_position;
  logic        tile_valid;
  logic [2:0]  status;
  logic [7:0]  map_width;
  logic [7:0]  map_height;
  logic        run_last;

  modport source (output valid, output tile_value, output tile_position,
                  output tile_valid, output status, output map_width,
                  output map_height, output run_last, input ready);
  modport sink   (input valid, input tile_value, input tile_position,
                  input tile_valid, input status, input map_width,
                  input map_height, input run_last, output ready);
endinterface

>>> rtl/core/tilemap_rle_decoder_top.sv
// -----------------------------------------------------------------------------
// Tilemap RLE decoder top level
// Decodes a run-length compressed tilemap into attribute and index tiles.
// -----------------------------------------------------------------------------
//   Channel  Dir  Handshake    Contents
//   in_if    in   valid/ready  data_byte, stream_start, stream_end
//   out_if   out  valid/ready  tile_value, tile_position, tile_valid, status,
//                              map_width, map_height, run_last
//
// The front end takes one byte per cycle while its four-entry command queue
// has room. The back end picks up one command at a time, writes attribute
// runs at one tile per cycle and then sends one result, and sends each index
// tile after a registered read of the attribute RAM; a result waits while the
// output is stalled. A byte without tiles still sends one result.
// Reset is asynchronous, active low; the attribute RAM is not cleared.
// A stalled output holds its transfer and fills the queue before in_if stalls.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilemap_rle_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  trd_byte_if.sink   in_if,
  trd_tile_if.source out_if
);
  import trd_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_out;

  trd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_in)
  );

  trd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  trd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_out),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );

endmodule

>>> rtl/core/trd_ram.sv
// -----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/trd_front.sv
// -----------------------------------------------------------------------------
// Tilemap RLE decoder front end
// Parses the byte stream, checks every command and issues tile work records.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  trd_byte_if.sink      in_if,
  input  logic          q_full_i,
  output logic          q_push_o,
  output trd_pkg::cmd_t q_cmd_o
);
  import trd_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  width_q, width_d, height_q, height_d;
  logic [15:0] total_q, total_d;
  logic [12:0] cursor_q, cursor_d;
  logic [7:0]  held_q, held_d;
  logic [10:0] last_idx_q, last_idx_d, incr_idx_q, incr_idx_d;
  logic        last_known_q, last_known_d, incr_known_q, incr_known_d;
  logic [2:0]  seen_q, seen_d;
  logic [2:0]  err_q, err_d;

  logic        accept;
  cmd_t        cmd;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && !q_full_i;
  assign q_push_o    = accept;
  assign q_cmd_o     = cmd;

  // Decode one byte against the current, or freshly cleared, state.
  always_comb begin
    logic [2:0]  ph;
    logic [7:0]  b;
    logic        active, rep;
    logic [15:0] prod;
    logic [16:0] reach;
    logic [9:0]  len;
    logic [10:0] value;

    b = in_if.data_byte;
    if (in_if.stream_start) begin
      ph = PH_HDR_W;
      width_d = '0; height_d = '0; total_d = '0; cursor_d = '0; held_d = '0;
      last_idx_d = '0; last_known_d = 1'b0; incr_idx_d = '0; incr_known_d = 1'b0;
      seen_d = '0; err_d = '0;
    end else begin
      ph = phase_q;
      width_d = width_q; height_d = height_q; total_d = total_q;
      cursor_d = cursor_q; held_d = held_q;
      last_idx_d = last_idx_q; last_known_d = last_known_q;
      incr_idx_d = incr_idx_q; incr_known_d = incr_known_q;
      seen_d = seen_q; err_d = err_q;
    end
    phase_d = ph;
    active  = ph < PH_DONE;
    if (active && seen_d < 3'd7) begin
      seen_d = seen_d + 3'd1;
    end
    prod  = '0;
    reach = '0;
    len   = '0;
    value = '0;
    rep   = 1'b0;

    cmd        = '0;
    cmd.kind   = CMD_NONE;
    cmd.addr   = cursor_d[AddrW-1:0];

    case (ph)
      PH_HDR_W: begin
        width_d = b;
        phase_d = PH_HDR_H;
      end
      PH_HDR_H: begin
        height_d = b;
        prod     = 16'(width_d) * 16'(b);
        total_d  = prod;
        if ({1'b0, prod} > 17'(MaxTiles)) begin
          phase_d = PH_ERROR; err_d = ST_ATTR_OVF;
        end else begin
          phase_d = PH_ATTR_A;
        end
      end
      PH_ATTR_A: begin
        if (in_if.stream_end) begin
          phase_d = PH_ERROR; err_d = ST_TRUNC;
        end else if (b[2]) begin
          len   = {8'd0, b[1:0]};
          reach = {4'd0, cursor_d} + {7'd0, len};
          if (reach >= {1'b0, total_d}) begin
            phase_d = PH_ERROR; err_d = ST_ATTR_OVF;
          end else begin
            cmd.kind = CMD_ATTR; cmd.count = len; cmd.attr = b[7:3];
            cursor_d = cursor_d + 13'(len) + 13'd1;
          end
        end else begin
          held_d  = b;
          phase_d = PH_ATTR_B;
        end
      end
      PH_ATTR_B: begin
        len = {held_d[1:0], b};
        if (len == 10'd0) begin
          if ({3'd0, cursor_d} != total_d) begin
            phase_d = PH_ERROR; err_d = ST_ATTR_MISM;
          end else begin
            cursor_d = '0;
            phase_d  = PH_IDX_A;
          end
        end else if (in_if.stream_end) begin
          phase_d = PH_ERROR; err_d = ST_TRUNC;
        end else begin
          reach = {4'd0, cursor_d} + {7'd0, len};
          if (reach >= {1'b0, total_d}) begin
            phase_d = PH_ERROR; err_d = ST_ATTR_OVF;
          end else begin
            cmd.kind = CMD_ATTR; cmd.count = len; cmd.attr = held_d[7:3];
            cursor_d = cursor_d + 13'(len) + 13'd1;
            phase_d  = PH_ATTR_A;
          end
        end
      end
      PH_IDX_A: begin
        rep = (b[7:6] == 2'd2);
        len = {4'd0, b[5:0]};
        if (in_if.stream_end) begin
          phase_d = PH_ERROR; err_d = ST_TRUNC;
        end else if (!b[7]) begin
          held_d  = b;
          phase_d = PH_IDX_B;
        end else if (rep && !last_known_d) begin
          phase_d = PH_ERROR; err_d = ST_NO_LAST;
        end else if (!rep && !incr_known_d) begin
          phase_d = PH_ERROR; err_d = ST_NO_INCR;
        end else begin
          reach = {4'd0, cursor_d} + {7'd0, len};
          if (reach >= {1'b0, total_d}) begin
            phase_d = PH_ERROR; err_d = ST_IDX_OVF;
          end else begin
            cmd.kind  = CMD_EMIT;
            cmd.count = len;
            cmd.step  = !rep;
            cmd.index = rep ? last_idx_d : incr_idx_d + 11'd1;
            if (!rep) begin
              incr_idx_d = incr_idx_d + 11'(len) + 11'd1;
            end
            cursor_d = cursor_d + 13'(len) + 13'd1;
          end
        end
      end
      PH_IDX_B: begin
        value   = {held_d[2:0], b};
        phase_d = PH_IDX_A;
        if (!held_d[6]) begin
          if (value == IdxEnd) begin
            phase_d = PH_DONE;
          end else if ({3'd0, cursor_d} >= total_d) begin
            phase_d = PH_ERROR; err_d = ST_IDX_OVF;
          end else begin
            cmd.kind = CMD_EMIT; cmd.index = value;
            cursor_d = cursor_d + 13'd1;
          end
        end else begin
          len   = {7'd0, held_d[5:3]};
          reach = {4'd0, cursor_d} + {7'd0, len};
          if (reach >= {1'b0, total_d}) begin
            phase_d = PH_ERROR; err_d = ST_IDX_OVF;
          end else begin
            cmd.kind = CMD_EMIT; cmd.count = len; cmd.index = value;
            cursor_d     = cursor_d + 13'(len) + 13'd1;
            last_idx_d   = value;
            last_known_d = 1'b1;
            if (!incr_known_d) begin
              incr_idx_d   = value;
              incr_known_d = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // End of stream: an unfinished map is truncated, short streams too.
    if (in_if.stream_end && active) begin
      if (phase_d == PH_ERROR) begin
        if (seen_d <= 3'd6) begin
          err_d = ST_TRUNC;
        end
      end else if (phase_d != PH_DONE) begin
        phase_d = PH_ERROR; err_d = ST_TRUNC;
      end
    end

    cmd.status = (phase_d == PH_DONE) ? ST_DONE :
                 (phase_d == PH_ERROR) ? err_d : ST_BUSY;
    cmd.width  = width_d;
    cmd.height = height_d;
  end

  // State registers advance on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR_W; width_q <= '0; height_q <= '0; total_q <= '0;
      cursor_q <= '0; held_q <= '0; last_idx_q <= '0; last_known_q <= 1'b0;
      incr_idx_q <= '0; incr_known_q <= 1'b0; seen_q <= '0; err_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d; width_q <= width_d; height_q <= height_d;
      total_q <= total_d; cursor_q <= cursor_d; held_q <= held_d;
      last_idx_q <= last_idx_d; last_known_q <= last_known_d;
      incr_idx_q <= incr_idx_d; incr_known_q <= incr_known_d;
      seen_q <= seen_d; err_q <= err_d;
    end
  end

endmodule

>>> rtl/core/trd_fifo.sv
// -----------------------------------------------------------------------------
// Tilemap RLE decoder command queue
// Short register queue that decouples the front end from the back end.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  trd_pkg::cmd_t entry_i,
  output logic          full_o,
  input  logic          pop_i,
  output trd_pkg::cmd_t entry_o,
  output logic          empty_o
);
  import trd_pkg::*;

  cmd_t           slot_q [QDepth];
  logic [QAw-1:0] wr_q, rd_q;
  logic [QAw:0]   cnt_q;

  assign full_o  = (cnt_q == (QAw+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAw'(1);
      end
      cnt_q <= cnt_q + (QAw+1)'(push_i) - (QAw+1)'(pop_i);
    end
  end

  // Payload storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/core/trd_back.sv
// -----------------------------------------------------------------------------
// Tilemap RLE decoder back end
// Writes attribute runs to the store, sends decoded tiles one by one and a tileless result for other bytes.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  trd_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  trd_tile_if.source    out_if
);
  import trd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_NONE  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]       state_q, state_d;
  cmd_t             cur_q, cur_d;
  logic             ovalid_q, ovalid_d;
  logic [15:0]      oval_q, oval_d;
  logic [11:0]      opos_q, opos_d;
  logic             otile_q, otile_d;
  logic [2:0]       ostat_q, ostat_d;
  logic [7:0]       ow_q, ow_d, oh_q, oh_d;
  logic             olast_q, olast_d;
  logic             slot_free;
  logic             ram_we, ram_re;
  logic [4:0]       ram_rdata;

  assign slot_free = !ovalid_q || out_if.ready;

  trd_ram #(.Width(5), .Depth(MaxTiles)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q.addr),
    .wdata_i (cur_q.attr),
    .re_i    (ram_re),
    .raddr_i (cur_q.addr),
    .rdata_o (ram_rdata)
  );

  // Sequencer over one command at a time.
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    q_pop_o  = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ovalid_d = ovalid_q && !out_if.ready;
    oval_d = oval_q; opos_d = opos_q; otile_d = otile_q; ostat_d = ostat_q;
    ow_d = ow_q; oh_d = oh_q; olast_d = olast_q;
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          case (q_cmd_i.kind)
            CMD_ATTR: state_d = S_WRITE;
            CMD_EMIT: state_d = S_READ;
            default:  state_d = S_NONE;
          endcase
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (cur_q.count == '0) begin
          state_d = S_NONE;
        end else begin
          cur_d.count = cur_q.count - 10'd1;
          cur_d.addr  = cur_q.addr + AddrW'(1);
        end
      end
      S_NONE: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          oval_d = '0; opos_d = '0; otile_d = 1'b0; olast_d = 1'b1;
          ostat_d = cur_q.status; ow_d = cur_q.width; oh_d = cur_q.height;
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          oval_d   = {ram_rdata, cur_q.index};
          opos_d   = 12'(cur_q.addr);
          otile_d  = 1'b1;
          olast_d  = (cur_q.count == '0);
          ostat_d  = cur_q.status; ow_d = cur_q.width; oh_d = cur_q.height;
          if (cur_q.count == '0) begin
            state_d = S_IDLE;
          end else begin
            cur_d.count = cur_q.count - 10'd1;
            cur_d.addr  = cur_q.addr + AddrW'(1);
            cur_d.index = cur_q.index + 11'(cur_q.step);
            state_d     = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Command and output payload.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    oval_q <= oval_d; opos_q <= opos_d; otile_q <= otile_d; ostat_q <= ostat_d;
    ow_q <= ow_d; oh_q <= oh_d; olast_q <= olast_d;
  end

  assign out_if.valid         = ovalid_q;
  assign out_if.tile_value    = oval_q;
  assign out_if.tile_position = opos_q;
  assign out_if.tile_valid    = otile_q;
  assign out_if.status        = ostat_q;
  assign out_if.map_width     = ow_q;
  assign out_if.map_height    = oh_q;
  assign out_if.run_last      = olast_q;

endmodule

>>> rtl/core/trd_checker.sv
// -----------------------------------------------------------------------------
// Tilemap RLE decoder checker
// Port-level assertions on the result channel, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [15:0] tile_value_i,
  input logic [11:0] tile_position_i,
  input logic        tile_valid_i,
  input logic [2:0]  status_i,
  input logic        run_last_i
);
  import trd_pkg::*;

  // A stalled result stays valid with its tile value and position held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(tile_value_i) &&
    $stable(tile_position_i))
    else $error("stalled result changed");

  // A result without a tile closes its byte on its own.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !tile_valid_i |-> run_last_i)
    else $error("tileless result not last");

  // A result without a tile carries zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !tile_valid_i |-> tile_value_i == 16'd0 && tile_position_i == 12'd0)
    else $error("tileless result has payload");

  // The end marker writes no tile.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i == ST_DONE |-> !tile_valid_i)
    else $error("tile sent with done status");

endmodule

bind tilemap_rle_decoder_top trd_checker u_trd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (out_if.valid),
  .ready_i         (out_if.ready),
  .tile_value_i    (out_if.tile_value),
  .tile_position_i (out_if.tile_position),
  .tile_valid_i    (out_if.tile_valid),
  .status_i        (out_if.status),
  .run_last_i      (out_if.run_last)
);
